// ===== hdl/modbus_rtu_read_input_slave_assert.svh =====
// ----------------------------------------------------------------------------
// Modbus RTU read-input slave assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_READ_INPUT_SLAVE_ASSERT_SVH
`define MODBUS_RTU_READ_INPUT_SLAVE_ASSERT_SVH

// same-cycle implication
`define MRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mrs assertion failed");

// next-cycle implication
`define MRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mrs assertion failed");

`endif

// ===== hdl/mrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrs_pkg
// Constants and types of the Modbus RTU read-input slave.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int NUM_REGS = 7;
  localparam int RIW      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  // reply length is 2*NUM_REGS+5 bytes; counter must hold that value too
  localparam int TXW      = $clog2(2 * NUM_REGS + 6);

  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [7:0]  SLAVE_ADDR_RST  = 8'h01;
  localparam logic [7:0]  REPLY_BYTE_CNT  = 8'(2 * NUM_REGS);

  // reply byte positions
  localparam logic [TXW-1:0] TX_ADDR   = TXW'(0);
  localparam logic [TXW-1:0] TX_FUNC   = TXW'(1);
  localparam logic [TXW-1:0] TX_COUNT  = TXW'(2);
  localparam logic [TXW-1:0] TX_DATA0  = TXW'(3);
  localparam logic [TXW-1:0] TX_CRC_LO = TXW'(3 + 2 * NUM_REGS);
  localparam logic [TXW-1:0] TX_CRC_HI = TXW'(4 + 2 * NUM_REGS);

  // request byte positions inside a frame
  localparam logic [2:0] RX_FUNC   = 3'd1;
  localparam logic [2:0] RX_ADDR_H = 3'd2;
  localparam logic [2:0] RX_ADDR_L = 3'd3;
  localparam logic [2:0] RX_QTY_H  = 3'd4;
  localparam logic [2:0] RX_QTY_L  = 3'd5;
  localparam logic [2:0] RX_CRC_L  = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RX_CRC,
    S_TX_LOAD,
    S_TX_CRC
  } state_e;

endpackage

// ===== hdl/mrs_intf.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU read-input slave channels
// Valid/ready channels for input items, reply bytes and the address register.
// ----------------------------------------------------------------------------
interface mrs_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        frame_start;
  logic [7:0]  rx_byte;
  logic [2:0]  reg_index;
  logic [15:0] reg_value;

  modport source (output valid, mode, frame_start, rx_byte, reg_index, reg_value,
                  input ready);
  modport sink (input valid, mode, frame_start, rx_byte, reg_index, reg_value,
                output ready);
endinterface

interface mrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, tx_byte, last_byte, input ready);
  modport sink (input valid, tx_byte, last_byte, output ready);
endinterface

interface mrs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/modbus_rtu_read_input_slave.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU read-input slave (function 04)
// Parses 8-byte requests, keeps the input register file, streams replies.
// ----------------------------------------------------------------------------
// A request byte that enters the CRC is accepted and then put through eight one-bit
// CRC steps in a shared bit-serial CRC unit; the address-byte CRC is the same. A
// reply has 2*NUM_REGS+5 bytes: each of the 2*NUM_REGS+3 leading bytes is loaded
// and then put through eight CRC bits, the two CRC bytes are only loaded, and
// every load waits for a free output slot. No input is taken while a CRC step
// or a reply is under way. The slave address register is written through cfg_i
// and resets to 1; the user is to write it only while the block is idle, as the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module modbus_rtu_read_input_slave
  import mrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mrs_cfg_if.sink    cfg_i,
  mrs_in_if.sink     in_i,
  mrs_out_if.source  out_o
);

  state_e state_q, state_d;

  logic [7:0]     slave_addr_q;
  logic [15:0]    regs_q [NUM_REGS];
  logic           frame_active_q;
  logic [2:0]     byte_cnt_q;
  logic [15:0]    crc_q;
  logic [7:0]     req_func_q;
  logic [15:0]    req_qty_q;
  logic [7:0]     rx_crc_lo_q;
  logic [2:0]     bit_cnt_q;
  logic [TXW-1:0] tx_cnt_q;
  logic [7:0]     tx_byte_q;
  logic           tx_last_q;
  logic           out_valid_q;

  logic           in_acc;
  logic           rx_byte_acc;
  logic           rx_feed;
  logic           rx_good;
  logic           slot_free;
  logic           tx_load;
  logic           tx_feed;
  logic [7:0]     tx_mux;
  logic [TXW-1:0] tx_off;
  logic [RIW-1:0] tx_ridx;
  logic [RIW-1:0] wr_idx;
  logic [15:0]    crc_shift;

  assign cfg_i.ready = 1'b1;
  assign out_o.valid     = out_valid_q;
  assign out_o.tx_byte   = tx_byte_q;
  assign out_o.last_byte = tx_last_q;

  assign in_acc      = in_i.valid && in_i.ready;
  assign rx_byte_acc = in_acc && !in_i.mode;
  assign slot_free   = !out_valid_q || out_o.ready;

  // bytes that go through the CRC: address byte and request bytes 1..5
  assign rx_feed = rx_byte_acc &&
                   (in_i.frame_start ||
                    (frame_active_q && byte_cnt_q >= RX_FUNC && byte_cnt_q <= RX_QTY_L));

  assign rx_good = rx_byte_acc && !in_i.frame_start && frame_active_q &&
                   byte_cnt_q > RX_CRC_L &&
                   rx_crc_lo_q == crc_q[7:0] && in_i.rx_byte == crc_q[15:8] &&
                   req_func_q == FUNC_READ_INPUT && req_qty_q <= 16'(NUM_REGS);

  // reply byte select
  assign tx_off  = tx_cnt_q - TX_DATA0;
  assign tx_ridx = tx_off[1 +: RIW];
  assign wr_idx  = RIW'(in_i.reg_index);

  always_comb begin
    priority if (tx_cnt_q == TX_ADDR) begin
      tx_mux = slave_addr_q;
    end else if (tx_cnt_q == TX_FUNC) begin
      tx_mux = FUNC_READ_INPUT;
    end else if (tx_cnt_q == TX_COUNT) begin
      tx_mux = REPLY_BYTE_CNT;
    end else if (tx_cnt_q < TX_CRC_LO) begin
      tx_mux = tx_off[0] ? regs_q[tx_ridx][7:0] : regs_q[tx_ridx][15:8];
    end else if (tx_cnt_q == TX_CRC_LO) begin
      tx_mux = crc_q[7:0];
    end else begin
      tx_mux = crc_q[15:8];
    end
  end

  assign crc_shift = {1'b0, crc_q[15:1]} ^ (crc_q[0] ? CRC_POLY : 16'h0000);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (rx_feed) begin
          state_d = S_RX_CRC;
        end else if (rx_good) begin
          state_d = S_TX_LOAD;
        end
      end
      S_RX_CRC: begin
        if (bit_cnt_q == 3'd0) state_d = S_IDLE;
      end
      S_TX_LOAD: begin
        if (slot_free) begin
          priority if (tx_cnt_q == TX_CRC_HI) begin
            state_d = S_IDLE;
          end else if (tx_cnt_q == TX_CRC_LO) begin
            state_d = S_TX_LOAD;
          end else begin
            state_d = S_TX_CRC;
          end
        end
      end
      S_TX_CRC: begin
        if (bit_cnt_q == 3'd0) state_d = S_TX_LOAD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_i.ready = 1'b0;
    tx_load    = 1'b0;
    unique case (state_q)
      S_IDLE:    in_i.ready = 1'b1;
      S_TX_LOAD: tx_load    = slot_free;
      S_RX_CRC,
      S_TX_CRC:  ;
      default:   ;
    endcase
  end

  assign tx_feed = tx_load && tx_cnt_q < TX_CRC_LO;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q   <= SLAVE_ADDR_RST;
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= 16'h0000;
      frame_active_q <= 1'b0;
      byte_cnt_q     <= 3'd0;
      crc_q          <= CRC_INIT;
      req_func_q     <= 8'h00;
      req_qty_q      <= 16'h0000;
      rx_crc_lo_q    <= 8'h00;
      bit_cnt_q      <= 3'd0;
      tx_cnt_q       <= '0;
      tx_byte_q      <= 8'h00;
      tx_last_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) slave_addr_q <= cfg_i.data;

      if (in_acc && in_i.mode && int'(in_i.reg_index) < NUM_REGS) begin
        regs_q[wr_idx] <= in_i.reg_value;
      end

      if (rx_byte_acc) begin
        if (in_i.frame_start) begin
          frame_active_q <= (in_i.rx_byte == slave_addr_q);
          byte_cnt_q     <= 3'd1;
          crc_q          <= CRC_INIT ^ {8'h00, in_i.rx_byte};
          req_func_q     <= 8'h00;
          req_qty_q      <= 16'h0000;
          rx_crc_lo_q    <= 8'h00;
        end else if (frame_active_q) begin
          if (byte_cnt_q <= RX_CRC_L) byte_cnt_q <= byte_cnt_q + 3'd1;
          priority if (byte_cnt_q > RX_CRC_L) begin
            // eighth byte closes the frame; on a good request the CRC restarts for the reply
            frame_active_q <= 1'b0;
            crc_q          <= CRC_INIT;
            tx_cnt_q       <= '0;
          end else if (byte_cnt_q == RX_CRC_L) begin
            rx_crc_lo_q <= in_i.rx_byte;
          end else begin
            crc_q <= crc_q ^ {8'h00, in_i.rx_byte};
            if (byte_cnt_q == RX_FUNC)  req_func_q       <= in_i.rx_byte;
            if (byte_cnt_q == RX_QTY_H) req_qty_q        <= {in_i.rx_byte, 8'h00};
            if (byte_cnt_q == RX_QTY_L) req_qty_q[7:0]   <= in_i.rx_byte;
          end
        end
      end

      if (rx_feed || tx_feed) begin
        bit_cnt_q <= 3'd7;
      end else if (state_q == S_RX_CRC || state_q == S_TX_CRC) begin
        crc_q <= crc_shift;
        // counter parks at zero after the last bit
        if (bit_cnt_q != 3'd0) bit_cnt_q <= bit_cnt_q - 3'd1;
      end

      if (tx_load) begin
        tx_byte_q   <= tx_mux;
        tx_last_q   <= (tx_cnt_q == TX_CRC_HI);
        out_valid_q <= 1'b1;
        tx_cnt_q    <= tx_cnt_q + TXW'(1);
        if (tx_feed) crc_q <= crc_q ^ {8'h00, tx_mux};
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`include "modbus_rtu_read_input_slave_assert.svh"

  // a non-final reply byte waiting means the reply is still being built
  `MRS_ASSERT_NOW(a_reply_in_progress, out_valid_q && !tx_last_q, state_q != S_IDLE)
  // the CRC bit counter only runs inside a CRC pass
  `MRS_ASSERT_NOW(a_bitcnt_in_crc, bit_cnt_q != 3'd0,
                  state_q == S_RX_CRC || state_q == S_TX_CRC)
  // loading the final CRC byte flags it as last
  `MRS_ASSERT_NEXT(a_last_flag, tx_load && tx_cnt_q == TX_CRC_HI,
                   out_valid_q && tx_last_q && state_q == S_IDLE)
  // an active frame has always counted its address byte
  `MRS_ASSERT_NOW(a_frame_count, frame_active_q, byte_cnt_q != 3'd0)

endmodule
